>>> sv/madt_pkg.sv
package madt_pkg;

    // Result kinds carried on the output tuser
    typedef enum logic [1:0] {
        KIND_IOC       = 2'd0,
        KIND_ISO       = 2'd1,
        KIND_MALFORMED = 2'd2,
        KIND_TRUNCATED = 2'd3
    } record_kind_t;

    // Entry type codes and minimum lengths
    localparam logic [7:0] ENTRY_IOC   = 8'd1;
    localparam logic [7:0] ENTRY_ISO   = 8'd2;
    localparam logic [7:0] MIN_LEN     = 8'd2;
    localparam logic [7:0] MIN_LEN_IOC = 8'd12;
    localparam logic [7:0] MIN_LEN_ISO = 8'd8;

    // Record queue between parser and output side
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        record_kind_t kind;
        logic [31:0]  unit_address;
        logic [31:0]  interrupt_number;
        logic [7:0]   source_irq;
    } record_t;

endpackage

>>> sv/madt_entry_parser_core.sv
// A record enters the record queue when the byte that ends its entry is taken, and is offered from the queue head.
// Throughput: one byte per cycle while the record queue is not full; field bytes are captured as they are taken.
// The four-record queue stalls input whenever it is full, also while the output is taking a record.
// Reset (rst_n low, asynchronous) clears the parser state, the halt flag and the queue.
module madt_entry_parser_core
    import madt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // table_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [31:0] unit_address, [63:32] interrupt_number,
                                   // [71:64] source_irq
    output logic [1:0]  m_tuser    // [1:0] record_kind
);

    logic    q_full;
    logic    rec_push;
    record_t rec;
    record_t head_rec;

    assign s_tready = !q_full;

    madt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_take  (s_tvalid && s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .rec_push (rec_push),
        .rec      (rec)
    );

    madt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (rec_push),
        .push_rec   (rec),
        .full       (q_full),
        .head_valid (m_tvalid),
        .head_take  (m_tready),
        .head_rec   (head_rec)
    );

    // Pack the head record onto the output stream
    assign m_tdata = {head_rec.source_irq, head_rec.interrupt_number, head_rec.unit_address};
    assign m_tuser = head_rec.kind;

endmodule

>>> sv/madt_front.sv
module madt_front
    import madt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_take,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       rec_push,
    output record_t    rec
);

    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  kind_reg, kind_next;
    logic [7:0]  len_reg, len_next;
    logic [31:0] addr_reg, addr_next;
    logic [31:0] gsi_reg, gsi_next;
    logic [7:0]  irq_reg, irq_next;
    logic        halted_reg, halted_next;

    logic [7:0]  kind_cur;
    logic [7:0]  len_cur;
    logic [31:0] addr_cur;
    logic [31:0] gsi_cur;
    logic [7:0]  irq_cur;
    logic [7:0]  need;
    logic        malformed;
    logic        complete;
    logic        clear;
    logic        in_window_lo;
    logic        in_window_hi;
    logic [4:0]  lane;

    // Current entry view: a new entry starts clean at position zero
    always_comb
    begin
        kind_cur = (pos_reg == 8'd0) ? in_byte : kind_reg;
        len_cur  = (pos_reg == 8'd1) ? in_byte : len_reg;
        addr_cur = (pos_reg == 8'd0) ? 32'd0 : addr_reg;
        gsi_cur  = (pos_reg == 8'd0) ? 32'd0 : gsi_reg;
        irq_cur  = (pos_reg == 8'd0) ? 8'd0 : irq_reg;
        lane     = {pos_reg[1:0], 3'b000};

        in_window_lo = (pos_reg >= 8'd4) && (pos_reg <= 8'd7);
        in_window_hi = (pos_reg >= 8'd8) && (pos_reg <= 8'd11);

        // Capture field bytes into their lanes
        if (pos_reg >= 8'd2)
        begin
            if (kind_cur == ENTRY_IOC)
            begin
                if (in_window_lo)
                    addr_cur[lane +: 8] = in_byte;
                else if (in_window_hi)
                    gsi_cur[lane +: 8] = in_byte;
            end
            else if (kind_cur == ENTRY_ISO)
            begin
                if (pos_reg == 8'd3)
                    irq_cur = in_byte;
                else if (in_window_lo)
                    gsi_cur[lane +: 8] = in_byte;
            end
        end

        // Length check on the length byte
        if (kind_cur == ENTRY_IOC)
            need = MIN_LEN_IOC;
        else if (kind_cur == ENTRY_ISO)
            need = MIN_LEN_ISO;
        else
            need = MIN_LEN;
        malformed = (pos_reg == 8'd1) && (in_byte < need);
        complete  = (pos_reg != 8'd0) &&
                    (({1'b0, pos_reg} + 9'd1) == {1'b0, len_cur});
    end

    // Next state and emitted record
    always_comb
    begin
        pos_next    = pos_reg;
        kind_next   = kind_reg;
        len_next    = len_reg;
        addr_next   = addr_reg;
        gsi_next    = gsi_reg;
        irq_next    = irq_reg;
        halted_next = halted_reg;
        rec_push    = 1'b0;
        rec         = '0;
        clear       = 1'b0;

        if (in_take)
        begin
            if (halted_reg)
            begin
                // Drop bytes until the table end
                if (in_last)
                begin
                    halted_next = 1'b0;
                    clear       = 1'b1;
                end
            end
            else if (malformed)
            begin
                rec_push    = 1'b1;
                rec.kind    = KIND_MALFORMED;
                halted_next = !in_last;
                clear       = 1'b1;
            end
            else if (complete)
            begin
                if (kind_cur == ENTRY_IOC)
                begin
                    rec_push             = 1'b1;
                    rec.kind             = KIND_IOC;
                    rec.unit_address     = addr_cur;
                    rec.interrupt_number = gsi_cur;
                end
                else if (kind_cur == ENTRY_ISO)
                begin
                    rec_push             = 1'b1;
                    rec.kind             = KIND_ISO;
                    rec.interrupt_number = gsi_cur;
                    rec.source_irq       = irq_cur;
                end
                clear = 1'b1;
            end
            else if (in_last)
            begin
                rec_push = 1'b1;
                rec.kind = KIND_TRUNCATED;
                clear    = 1'b1;
            end
            else
            begin
                pos_next  = pos_reg + 8'd1;
                kind_next = kind_cur;
                len_next  = len_cur;
                addr_next = addr_cur;
                gsi_next  = gsi_cur;
                irq_next  = irq_cur;
            end

            // Restart at a fresh entry
            if (clear)
            begin
                pos_next  = 8'd0;
                kind_next = 8'd0;
                len_next  = 8'd0;
                addr_next = 32'd0;
                gsi_next  = 32'd0;
                irq_next  = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 8'd0;
            kind_reg   <= 8'd0;
            len_reg    <= 8'd0;
            addr_reg   <= 32'd0;
            gsi_reg    <= 32'd0;
            irq_reg    <= 8'd0;
            halted_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            kind_reg   <= kind_next;
            len_reg    <= len_next;
            addr_reg   <= addr_next;
            gsi_reg    <= gsi_next;
            irq_reg    <= irq_next;
            halted_reg <= halted_next;
        end
    end

endmodule

>>> sv/madt_queue.sv
module madt_queue
    import madt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  record_t push_rec,
    output logic    full,
    output logic    head_valid,
    input  logic    head_take,
    output record_t head_rec
);

    record_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_rec   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = head_take && head_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold record payloads
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_rec;
    end

endmodule
